// ===== sv/mstep_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mstep_pkg
// Shared types, opcodes and sizes for the MIPS subset instruction step core.
// ----------------------------------------------------------------------------
package mstep_pkg;

   localparam int unsigned DATA_WORDS  = 1024;
   localparam int unsigned DMEM_AW     = $clog2(DATA_WORDS);
   localparam int unsigned MEM_INDEX_W = 10;
   localparam int unsigned CSR_AW      = 3;

   localparam logic [31:0] START_PC_RESET  = 32'h0040_0000;
   localparam logic [31:0] DATA_BASE_RESET = 32'h1000_0000;

   // register offsets, selected by paddr[2]
   localparam logic CSR_START_PC  = 1'b0;
   localparam logic CSR_DATA_BASE = 1'b1;

   localparam logic MODE_EXEC    = 1'b0;
   localparam logic MODE_PRELOAD = 1'b1;

   localparam logic [5:0] OP_RTYPE = 6'h00;
   localparam logic [5:0] OP_J     = 6'h02;
   localparam logic [5:0] OP_BEQ   = 6'h04;
   localparam logic [5:0] OP_BNE   = 6'h05;
   localparam logic [5:0] OP_ADDI  = 6'h08;
   localparam logic [5:0] OP_SLTI  = 6'h0A;
   localparam logic [5:0] OP_ANDI  = 6'h0C;
   localparam logic [5:0] OP_ORI   = 6'h0D;
   localparam logic [5:0] OP_LUI   = 6'h0F;
   localparam logic [5:0] OP_LW    = 6'h23;
   localparam logic [5:0] OP_SW    = 6'h2B;

   localparam logic [5:0] FN_NOP = 6'h00;
   localparam logic [5:0] FN_ADD = 6'h20;
   localparam logic [5:0] FN_SUB = 6'h22;
   localparam logic [5:0] FN_AND = 6'h24;
   localparam logic [5:0] FN_OR  = 6'h25;
   localparam logic [5:0] FN_SLT = 6'h2A;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_INST = 2'd1,
      ST_BAD_ADDR = 2'd2
   } status_type;

   typedef struct packed {
      logic [31:0]            next_pc;
      status_type             status;
      logic                   reg_written;
      logic [4:0]             reg_index;
      logic [31:0]            reg_value;
      logic                   is_load;
      logic                   mem_written;
      logic [MEM_INDEX_W-1:0] mem_index;
      logic [31:0]            mem_value;
   } exec_res_type;

   typedef struct packed {
      logic               en;
      logic               we;
      logic [DMEM_AW-1:0] addr;
      logic [31:0]        wdata;
   } dmem_req_type;

   typedef struct packed {
      logic        en;
      logic [4:0]  addr;
      logic [31:0] data;
   } rf_wr_type;

   typedef struct packed {
      logic        start_pc_we;
      logic [31:0] start_pc;
      logic [31:0] data_base;
   } csr_out_type;

endpackage
`default_nettype wire

// ===== sv/mstep_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mstep_req_if
// Request channel: one instruction or one preload word per beat.
// ----------------------------------------------------------------------------
interface mstep_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [31:0] instruction;
   logic [9:0]  preload_index;
   logic [31:0] preload_value;

   modport source (output valid, mode, instruction, preload_index, preload_value,
                   input ready);
   modport sink   (input valid, mode, instruction, preload_index, preload_value,
                   output ready);
endinterface
`default_nettype wire

// ===== sv/mstep_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mstep_rsp_if
// Response channel: one result beat per request beat.
// ----------------------------------------------------------------------------
interface mstep_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] next_pc;
   logic [1:0]  status;
   logic        reg_written;
   logic [4:0]  reg_index;
   logic [31:0] reg_value;
   logic        mem_written;
   logic [9:0]  mem_index;
   logic [31:0] mem_value;

   modport source (output valid, next_pc, status, reg_written, reg_index, reg_value,
                   mem_written, mem_index, mem_value,
                   input ready);
   modport sink   (input valid, next_pc, status, reg_written, reg_index, reg_value,
                   mem_written, mem_index, mem_value,
                   output ready);
endinterface
`default_nettype wire

// ===== sv/mips_subset_instruction_step_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mips_subset_instruction_step_core
// A request beat is held in the execute register, then its result in the result register, which offers the result beat.
// Throughput: one beat per cycle while rsp.ready is high and no clear runs; operands bypass from the result register.
// Reset: registers zero, PC = start_pc; data memory sweeps every word to
// zero with req.ready low, csr writes still taken.
// ----------------------------------------------------------------------------
module mips_subset_instruction_step_core
   import mstep_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   mstep_req_if.sink              req,
   mstep_rsp_if.source            rsp,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output      logic [31:0]       prdata,
   output      logic              pready
);

   csr_out_type  csr;
   exec_res_type x_res;
   dmem_req_type dreq;
   dmem_req_type dreq_gated;
   rf_wr_type    rf_wr;

   logic        x_valid_ff;
   logic        x_valid_in;
   logic        x_mode_ff;
   logic [31:0] x_inst_ff;
   logic [9:0]  x_pidx_ff;
   logic [31:0] x_pval_ff;
   logic        w_valid_ff;
   logic        w_valid_in;
   exec_res_type w_res_ff;
   logic [31:0] pc_ff;
   logic [31:0] pc_in;

   logic [31:0] rf_a;
   logic [31:0] rf_b;
   logic [31:0] op_a;
   logic [31:0] op_b;
   logic [31:0] w_reg_value;
   logic [31:0] dmem_rdata;
   logic        clr_busy;
   logic        w_free;
   logic        x_move;
   logic        x_load;
   logic        rsp_take;

   mstep_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .csr     (csr)
   );

   // pipeline control
   assign rsp_take  = w_valid_ff && rsp.ready;
   assign w_free    = !w_valid_ff || rsp.ready;
   assign x_move    = x_valid_ff && w_free;
   assign req.ready = (!x_valid_ff || x_move) && !clr_busy;
   assign x_load    = req.valid && req.ready;

   assign x_valid_in = x_load ? 1'b1 : (x_move ? 1'b0 : x_valid_ff);
   assign w_valid_in = x_move ? 1'b1 : (rsp.ready ? 1'b0 : w_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff <= 1'b0;
         w_valid_ff <= 1'b0;
      end else begin
         x_valid_ff <= x_valid_in;
         w_valid_ff <= w_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (x_load) begin
         x_mode_ff <= req.mode;
         x_inst_ff <= req.instruction;
         x_pidx_ff <= req.preload_index;
         x_pval_ff <= req.preload_value;
      end
      if (x_move) begin
         w_res_ff <= x_res;
      end
   end

   always_comb begin
      pc_in = pc_ff;
      if (csr.start_pc_we) begin
         pc_in = csr.start_pc;
      end else if (x_move) begin
         pc_in = x_res.next_pc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= START_PC_RESET;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // register file: write on result beat, read on request beat
   assign w_reg_value = w_res_ff.is_load ? dmem_rdata : w_res_ff.reg_value;

   assign rf_wr.en   = rsp_take && w_res_ff.reg_written;
   assign rf_wr.addr = w_res_ff.reg_index;
   assign rf_wr.data = w_reg_value;

   mstep_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (x_load),
      .rd_addr_a (req.instruction[25:21]),
      .rd_addr_b (req.instruction[20:16]),
      .rd_data_a (rf_a),
      .rd_data_b (rf_b),
      .wr        (rf_wr)
   );

   // bypass from the result register
   always_comb begin
      op_a = rf_a;
      op_b = rf_b;
      if (w_valid_ff && w_res_ff.reg_written) begin
         if (w_res_ff.reg_index == x_inst_ff[25:21]) begin
            op_a = w_reg_value;
         end
         if (w_res_ff.reg_index == x_inst_ff[20:16]) begin
            op_b = w_reg_value;
         end
      end
   end

   mstep_exec u_exec (
      .mode          (x_mode_ff),
      .instruction   (x_inst_ff),
      .preload_index (x_pidx_ff),
      .preload_value (x_pval_ff),
      .op_a          (op_a),
      .op_b          (op_b),
      .pc            (pc_ff),
      .data_base     (csr.data_base),
      .res           (x_res),
      .dreq          (dreq)
   );

   always_comb begin
      dreq_gated    = dreq;
      dreq_gated.en = dreq.en && x_move;
   end

   mstep_dmem u_dmem (
      .clock   (clock),
      .reset   (reset),
      .req_in  (dreq_gated),
      .rd_data (dmem_rdata),
      .busy    (clr_busy)
   );

   assign rsp.valid       = w_valid_ff;
   assign rsp.next_pc     = w_res_ff.next_pc;
   assign rsp.status      = w_res_ff.status;
   assign rsp.reg_written = w_res_ff.reg_written;
   assign rsp.reg_index   = w_res_ff.reg_index;
   assign rsp.reg_value   = w_reg_value;
   assign rsp.mem_written = w_res_ff.mem_written;
   assign rsp.mem_index   = w_res_ff.mem_index;
   assign rsp.mem_value   = w_res_ff.mem_value;

   a_no_item_while_clearing : assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !x_valid_ff && !w_valid_ff)
      else $error("item in flight during data memory clear");

   a_move_fills_result : assert property (@(posedge clock) disable iff (reset)
      x_move |=> rsp.valid)
      else $error("execute stage advanced without a result beat");

   a_no_write_to_r0 : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.reg_written |-> rsp.reg_index != 5'd0)
      else $error("result writes register zero");

   a_error_no_write : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status != ST_OK |-> !rsp.reg_written && !rsp.mem_written)
      else $error("error result carries a write");

   a_preload_keeps_pc : assert property (@(posedge clock) disable iff (reset)
      x_move && x_mode_ff == MODE_PRELOAD |=> rsp.next_pc == $past(pc_ff))
      else $error("preload changed the program counter");

endmodule
`default_nettype wire

// ===== sv/mstep_regfile.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mstep_regfile
// 32 x 32 register file, two registered read ports, one write port with
// write-to-read bypass. Per-entry valid bits make unwritten entries read zero.
// ----------------------------------------------------------------------------
module mstep_regfile
   import mstep_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        rd_en,
   input  wire logic [4:0]  rd_addr_a,
   input  wire logic [4:0]  rd_addr_b,
   output      logic [31:0] rd_data_a,
   output      logic [31:0] rd_data_b,
   input  wire rf_wr_type   wr
);

   logic [31:0] mem [32];
   logic [31:0] valid_ff;
   logic [31:0] valid_in;
   logic [31:0] rd_data_a_ff;
   logic [31:0] rd_data_b_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr.en && wr.addr == rd_addr_a) begin
            rd_data_a_ff <= wr.data;
         end else begin
            rd_data_a_ff <= valid_ff[rd_addr_a] ? mem[rd_addr_a] : '0;
         end
         if (wr.en && wr.addr == rd_addr_b) begin
            rd_data_b_ff <= wr.data;
         end else begin
            rd_data_b_ff <= valid_ff[rd_addr_b] ? mem[rd_addr_b] : '0;
         end
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule
`default_nettype wire

// ===== sv/mstep_dmem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mstep_dmem
// Word data memory, single port, registered read data. Sweeps every word
// to zero after reset and reports busy until done.
// ----------------------------------------------------------------------------
module mstep_dmem
   import mstep_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire dmem_req_type req_in,
   output      logic [31:0]  rd_data,
   output      logic         busy
);

   logic [31:0]        mem [DATA_WORDS];
   logic [31:0]        rd_data_ff;
   logic               busy_ff;
   logic               busy_in;
   logic [DMEM_AW-1:0] clr_addr_ff;
   logic [DMEM_AW-1:0] clr_addr_in;

   always_comb begin
      busy_in     = busy_ff;
      clr_addr_in = clr_addr_ff;
      if (busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == DMEM_AW'(DATA_WORDS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (req_in.en && req_in.we) begin
         mem[req_in.addr] <= req_in.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (!busy_ff && req_in.en && !req_in.we) begin
         rd_data_ff <= mem[req_in.addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule
`default_nettype wire

// ===== sv/mstep_exec.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mstep_exec
// Decode and execute one item: ALU, branch and jump target, data address
// and range check, preload handling.
// ----------------------------------------------------------------------------
module mstep_exec
   import mstep_pkg::*;
(
   input  wire logic         mode,
   input  wire logic [31:0]  instruction,
   input  wire logic [9:0]   preload_index,
   input  wire logic [31:0]  preload_value,
   input  wire logic [31:0]  op_a,
   input  wire logic [31:0]  op_b,
   input  wire logic [31:0]  pc,
   input  wire logic [31:0]  data_base,
   output      exec_res_type res,
   output      dmem_req_type dreq
);

   logic [5:0]  op;
   logic [5:0]  funct;
   logic [4:0]  rt;
   logic [4:0]  rd;
   logic [31:0] uimm;
   logic [31:0] simm;
   logic [31:0] pc4;
   logic [31:0] byte_addr;
   logic [29:0] word_idx;
   logic        word_ok;
   logic [31:0] pidx_ext;
   logic        pidx_ok;
   logic        wr_en;
   logic [4:0]  wr_idx;
   logic [31:0] wr_val;
   logic        load;
   logic        wr_live;

   assign op        = instruction[31:26];
   assign rt        = instruction[20:16];
   assign rd        = instruction[15:11];
   assign funct     = instruction[5:0];
   assign uimm      = {16'h0000, instruction[15:0]};
   assign simm      = {{16{instruction[15]}}, instruction[15:0]};
   assign pc4       = pc + 32'd4;
   assign byte_addr = op_a + simm - data_base;
   assign word_idx  = byte_addr[31:2];
   assign word_ok   = word_idx < 30'(DATA_WORDS);
   assign pidx_ext  = {22'h0, preload_index};
   assign pidx_ok   = pidx_ext < 32'(DATA_WORDS);

   always_comb begin
      res         = '0;
      res.next_pc = pc4;
      res.status  = ST_OK;
      dreq        = '0;
      wr_en       = 1'b0;
      wr_idx      = '0;
      wr_val      = '0;
      load        = 1'b0;

      if (mode == MODE_PRELOAD) begin
         res.next_pc = pc;
         if (pidx_ok) begin
            res.mem_written = 1'b1;
            res.mem_index   = preload_index;
            res.mem_value   = preload_value;
            dreq.en         = 1'b1;
            dreq.we         = 1'b1;
            dreq.addr       = pidx_ext[DMEM_AW-1:0];
            dreq.wdata      = preload_value;
         end else begin
            res.status = ST_BAD_ADDR;
         end
      end else begin
         case (op)
            OP_RTYPE: begin
               wr_idx = rd;
               case (funct)
                  FN_NOP: begin
                  end
                  FN_ADD: begin
                     wr_en  = 1'b1;
                     wr_val = op_a + op_b;
                  end
                  FN_SUB: begin
                     wr_en  = 1'b1;
                     wr_val = op_a - op_b;
                  end
                  FN_AND: begin
                     wr_en  = 1'b1;
                     wr_val = op_a & op_b;
                  end
                  FN_OR: begin
                     wr_en  = 1'b1;
                     wr_val = op_a | op_b;
                  end
                  FN_SLT: begin
                     wr_en  = 1'b1;
                     wr_val = {31'h0, $signed(op_a) < $signed(op_b)};
                  end
                  default: begin
                     res.status = ST_BAD_INST;
                  end
               endcase
            end
            OP_ADDI: begin
               wr_en  = 1'b1;
               wr_idx = rt;
               wr_val = op_a + simm;
            end
            OP_ANDI: begin
               wr_en  = 1'b1;
               wr_idx = rt;
               wr_val = op_a & uimm;
            end
            OP_ORI: begin
               wr_en  = 1'b1;
               wr_idx = rt;
               wr_val = op_a | uimm;
            end
            OP_SLTI: begin
               wr_en  = 1'b1;
               wr_idx = rt;
               wr_val = {31'h0, $signed(op_a) < $signed(simm)};
            end
            OP_LUI: begin
               wr_en  = 1'b1;
               wr_idx = rt;
               wr_val = {instruction[15:0], 16'h0000};
            end
            OP_LW: begin
               wr_idx = rt;
               if (word_ok) begin
                  wr_en = 1'b1;
                  load  = 1'b1;
               end else begin
                  res.status = ST_BAD_ADDR;
               end
            end
            OP_SW: begin
               if (word_ok) begin
                  res.mem_written = 1'b1;
                  res.mem_index   = word_idx[MEM_INDEX_W-1:0];
                  res.mem_value   = op_b;
                  dreq.en         = 1'b1;
                  dreq.we         = 1'b1;
                  dreq.addr       = word_idx[DMEM_AW-1:0];
                  dreq.wdata      = op_b;
               end else begin
                  res.status = ST_BAD_ADDR;
               end
            end
            OP_BEQ: begin
               if (op_a == op_b) begin
                  res.next_pc = pc4 + {simm[29:0], 2'b00};
               end
            end
            OP_BNE: begin
               if (op_a != op_b) begin
                  res.next_pc = pc4 + {simm[29:0], 2'b00};
               end
            end
            OP_J: begin
               res.next_pc = {pc4[31:28], instruction[25:0], 2'b00};
            end
            default: begin
               res.status = ST_BAD_INST;
            end
         endcase
      end

      // drop writes to register zero
      wr_live = wr_en && (wr_idx != 5'd0);
      if (wr_live) begin
         res.reg_written = 1'b1;
         res.reg_index   = wr_idx;
         res.reg_value   = load ? 32'h0 : wr_val;
         res.is_load     = load;
      end
      if (wr_live && load) begin
         dreq.en   = 1'b1;
         dreq.we   = 1'b0;
         dreq.addr = word_idx[DMEM_AW-1:0];
      end
   end

endmodule
`default_nettype wire

// ===== sv/mstep_csr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mstep_csr
// APB register block: start_pc and data_base.
// ----------------------------------------------------------------------------
module mstep_csr
   import mstep_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output      logic [31:0]       prdata,
   output      logic              pready,
   output      csr_out_type       csr
);

   logic [31:0] start_pc_ff;
   logic [31:0] start_pc_in;
   logic [31:0] data_base_ff;
   logic [31:0] data_base_in;
   logic        wr;
   logic        sel;

   assign wr  = psel && penable && pwrite;
   assign sel = paddr[2];

   always_comb begin
      start_pc_in  = start_pc_ff;
      data_base_in = data_base_ff;
      if (wr) begin
         case (sel)
            CSR_START_PC:  start_pc_in  = pwdata;
            CSR_DATA_BASE: data_base_in = pwdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_pc_ff  <= START_PC_RESET;
         data_base_ff <= DATA_BASE_RESET;
      end else begin
         start_pc_ff  <= start_pc_in;
         data_base_ff <= data_base_in;
      end
   end

   always_comb begin
      case (sel)
         CSR_START_PC:  prdata = start_pc_ff;
         CSR_DATA_BASE: prdata = data_base_ff;
         default:       prdata = '0;
      endcase
   end

   assign pready          = 1'b1;
   assign csr.start_pc_we = wr && (sel == CSR_START_PC);
   assign csr.start_pc    = pwdata;
   assign csr.data_base   = data_base_ff;

endmodule
`default_nettype wire
